/* rtl/ups_pkg.sv */
// shared types and constants for the integer pixel replication upscaler
// no dependencies; imported by every other file of the block
package ups_pkg;

  localparam int PIXEL_W       = 24;
  localparam int SCALE_FIELD_W = 7;
  localparam int WIDTH_FIELD_W = 13;
  localparam int HEIGHT_W      = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PIXEL       = 2'd0,
    ST_PUSH_OK     = 2'd1,
    ST_PUSH_REJECT = 2'd2,
    ST_NO_ROW      = 2'd3
  } status_t;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] pad_bytes;
    logic       row_end;
    logic       image_end;
  } tag_t;

  typedef struct packed {
    tag_t   tag;
    pixel_t pixel;
  } result_t;

endpackage

/* rtl/ups_if.sv */
// valid/ready channel interfaces for the upscaler request and result items
// depends on ups_pkg
interface ups_req_if import ups_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  pixel_t  pixel_in;

  modport source (output valid, output opcode, output pixel_in, input ready);
  modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

interface ups_rsp_if import ups_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  pixel_t     pixel_out;
  logic [1:0] pad_bytes;
  logic       row_end;
  logic       image_end;

  modport source (output valid, output status, output pixel_out, output pad_bytes,
                  output row_end, output image_end, input ready);
  modport sink (input valid, input status, input pixel_out, input pad_bytes,
                input row_end, input image_end, output ready);
endinterface

/* rtl/ups_front.sv */
// front end: accepts items, holds configuration, counters and the line store,
// classifies each item and hands a tagged result to the queue; depends on ups_pkg, ups_if
module ups_front import ups_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  ups_req_if.sink                req,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [QCOUNT_W-1:0]    q_count,
  output logic                   push_valid,
  output result_t                push_item
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int CSW = ((CW > AW) ? CW : AW) + 1;
  localparam int SW  = $clog2(MAX_SCALE + 1);
  localparam int SSW = SW + 1;
  localparam int HSW = HEIGHT_W + 1;

  // effective configuration
  logic [SW-1:0]       scale_eff;
  logic [CW-1:0]       width_eff;
  logic [HEIGHT_W-1:0] height_eff;

  logic [AW-1:0]       fill_column, fill_column_next;
  logic                row_ready, row_ready_next;
  logic [AW-1:0]       read_column, read_column_next;
  logic [SW-1:0]       across_repeat, across_repeat_next;
  logic [SW-1:0]       down_repeat, down_repeat_next;
  logic [HEIGHT_W-1:0] source_row, source_row_next;

  logic                stage_valid;
  tag_t                stage_tag, stage_tag_next;
  pixel_t              rdata;

  logic [PIXEL_W-1:0]  line_store [MAX_WIDTH];

  logic                accept;
  logic                wr_en;
  logic                rd_en;
  logic [CSW-1:0]      fill_sum, read_sum, width_cmp;
  logic [SSW-1:0]      across_sum, down_sum, scale_cmp;
  logic [HSW-1:0]      row_sum;
  logic [31:0]         scale_raw, width_raw, width_ext, scale_ext;
  logic [1:0]          pad_value;

  assign req.ready = (32'(q_count) + 32'(stage_valid)) < QUEUE_DEPTH;
  assign accept    = req.valid && req.ready;

  assign fill_sum   = CSW'(fill_column) + 1'b1;
  assign read_sum   = CSW'(read_column) + 1'b1;
  assign width_cmp  = CSW'(width_eff);
  assign across_sum = SSW'(across_repeat) + 1'b1;
  assign down_sum   = SSW'(down_repeat) + 1'b1;
  assign scale_cmp  = SSW'(scale_eff);
  assign row_sum    = HSW'(source_row) + 1'b1;

  assign width_ext = 32'(width_eff);
  assign scale_ext = 32'(scale_eff);
  assign pad_value = 2'(width_ext[1:0] * scale_ext[1:0]);

  assign scale_raw = 32'(cfg_data[SCALE_FIELD_W-1:0]);
  assign width_raw = 32'(cfg_data[WIDTH_FIELD_W-1:0]);

  // configuration registers, stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_eff  <= SW'(1);
      width_eff  <= CW'(1);
      height_eff <= HEIGHT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: begin
          if (scale_raw == 32'd0) scale_eff <= SW'(1);
          else if (scale_raw > 32'(MAX_SCALE)) scale_eff <= SW'(MAX_SCALE);
          else scale_eff <= SW'(scale_raw);
        end
        REG_WIDTH: begin
          if (width_raw == 32'd0) width_eff <= CW'(1);
          else if (width_raw > 32'(MAX_WIDTH)) width_eff <= CW'(MAX_WIDTH);
          else width_eff <= CW'(width_raw);
        end
        REG_HEIGHT: begin
          if (cfg_data[HEIGHT_W-1:0] == '0) height_eff <= HEIGHT_W'(1);
          else height_eff <= cfg_data[HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    fill_column_next   = fill_column;
    row_ready_next     = row_ready;
    read_column_next   = read_column;
    across_repeat_next = across_repeat;
    down_repeat_next   = down_repeat;
    source_row_next    = source_row;
    stage_tag_next     = '{status: ST_PUSH_OK, pad_bytes: 2'd0, row_end: 1'b0,
                           image_end: 1'b0};
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    if (accept) begin
      if (req.opcode == OP_PUSH) begin
        if (row_ready) begin
          stage_tag_next.status = ST_PUSH_REJECT;
        end else begin
          wr_en = 1'b1;
          stage_tag_next.status = ST_PUSH_OK;
          if (fill_sum >= width_cmp) begin
            fill_column_next   = '0;
            row_ready_next     = 1'b1;
            read_column_next   = '0;
            across_repeat_next = '0;
            down_repeat_next   = '0;
          end else begin
            fill_column_next = AW'(fill_sum);
          end
        end
      end else begin
        if (!row_ready) begin
          stage_tag_next.status = ST_NO_ROW;
        end else begin
          rd_en = 1'b1;
          stage_tag_next.status = ST_PIXEL;
          if (across_sum >= scale_cmp) begin
            across_repeat_next = '0;
            if (read_sum >= width_cmp) begin
              read_column_next         = '0;
              stage_tag_next.row_end   = 1'b1;
              stage_tag_next.pad_bytes = pad_value;
              if (down_sum >= scale_cmp) begin
                down_repeat_next = '0;
                row_ready_next   = 1'b0;
                if (row_sum >= HSW'(height_eff)) begin
                  stage_tag_next.image_end = 1'b1;
                  source_row_next          = '0;
                end else begin
                  source_row_next = HEIGHT_W'(row_sum);
                end
              end else begin
                down_repeat_next = SW'(down_sum);
              end
            end else begin
              read_column_next = AW'(read_sum);
            end
          end else begin
            across_repeat_next = SW'(across_sum);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_column   <= '0;
      row_ready     <= 1'b0;
      read_column   <= '0;
      across_repeat <= '0;
      down_repeat   <= '0;
      source_row    <= '0;
      stage_valid   <= 1'b0;
    end else begin
      fill_column   <= fill_column_next;
      row_ready     <= row_ready_next;
      read_column   <= read_column_next;
      across_repeat <= across_repeat_next;
      down_repeat   <= down_repeat_next;
      source_row    <= source_row_next;
      stage_valid   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage_tag <= stage_tag_next;
  end

  // line store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[fill_column] <= req.pixel_in;
    end
    if (rd_en) begin
      rdata <= line_store[read_column];
    end
  end

  assign push_valid = stage_valid;
  assign push_item  = '{tag: stage_tag, pixel: rdata};

endmodule

/* rtl/ups_queue.sv */
// short result queue between the front end and the output stage
// depends on ups_pkg
module ups_queue import ups_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  result_t             push_item,
  input  logic                pop,
  output result_t             head,
  output logic [QCOUNT_W-1:0] count
);

  result_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push_valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head = slots[rd_ptr];

endmodule

/* rtl/ups_back.sv */
// output stage: takes tagged results from the queue into the output register
// and masks the pixel of non-emitting items; depends on ups_pkg, ups_if
module ups_back import ups_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  result_t             head,
  input  logic [QCOUNT_W-1:0] count,
  output logic                pop,
  ups_rsp_if.source           rsp
);

  logic head_valid;

  assign head_valid = count != '0;
  assign pop        = head_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (!rsp.valid || rsp.ready) begin
      rsp.valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.status    <= head.tag.status;
      rsp.pixel_out <= (head.tag.status == ST_PIXEL) ? head.pixel : '0;
      rsp.pad_bytes <= head.tag.pad_bytes;
      rsp.row_end   <= head.tag.row_end;
      rsp.image_end <= head.tag.image_end;
    end
  end

endmodule

/* rtl/integer_pixel_replication_upscaler.sv */
// Nearest-neighbor integer upscaler for 24-bit pixels. Push items fill a line store with one
// source row; once the row is complete, each pull item returns the next replicated output pixel,
// with row_end, pad_bytes and image_end on the row and image boundaries. Every item gives exactly
// one result. One item is taken per clock while the output is not stalled: the line store does one
// write or one read per cycle and all counters update in the accept cycle. A result reaches the
// output through the line store read, the result queue and the output register, later while the
// output is stalled. The user must write configuration only while no item is in flight; the block
// does not enforce this. Depends on ups_pkg, ups_if, ups_front, ups_queue and ups_back.
module integer_pixel_replication_upscaler import ups_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_SCALE = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  ups_req_if.sink                req,
  ups_rsp_if.source              rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                push_valid;
  result_t             push_item;
  logic                pop;
  result_t             head;
  logic [QCOUNT_W-1:0] count;

  ups_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_count    (count),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  ups_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .count      (count)
  );

  ups_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .count (count),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule
